>>> hdl/assert_macros.svh
// Assertion helper macros used by the RTL controller
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication checked at every edge outside reset
`define ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication checked outside reset
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> hdl/gffr_pkg.sv
// ----------------------------------------------------------------------------
// gffr_pkg
// Shared types and constants for the grid flood fill relabel block.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package gffr_pkg;

    localparam int MAX_WIDTH  = 128;
    localparam int MAX_HEIGHT = 64;
    localparam int XW         = $clog2(MAX_WIDTH);
    localparam int YW         = $clog2(MAX_HEIGHT);
    localparam int AW         = XW + YW;
    localparam int CELLS      = MAX_WIDTH * MAX_HEIGHT;
    localparam int CW         = $clog2(CELLS + 1);

    typedef enum logic [1:0] {
        REQ_WRITE = 2'd0,
        REQ_READ  = 2'd1,
        REQ_FILL  = 2'd2,
        REQ_FIRST = 2'd3
    } t_req;

    typedef enum logic [1:0] {
        ST_OK      = 2'd0,
        ST_COORD   = 2'd1,
        ST_SAME    = 2'd2,
        ST_NOMATCH = 2'd3
    } t_status;

    localparam logic CFG_WIDTH  = 1'b0;
    localparam logic CFG_HEIGHT = 1'b1;

    typedef struct packed {
        logic [1:0] req_type;
        logic [6:0] pos_x;
        logic [5:0] pos_y;
        logic [1:0] match_kind;
        logic [1:0] new_kind;
    } t_in;

    typedef struct packed {
        logic [1:0]  read_kind;
        logic [13:0] changed_count;
        logic [13:0] remaining_count;
        logic [6:0]  seed_x;
        logic [5:0]  seed_y;
        logic [1:0]  status;
    } t_out;

    // Grid memory operations
    typedef enum logic [1:0] {
        GOP_NONE  = 2'd0,
        GOP_READ  = 2'd1,
        GOP_WRITE = 2'd2
    } t_gop;

    // Datapath address source
    typedef enum logic [2:0] {
        ASEL_POS  = 3'd0,
        ASEL_SCAN = 3'd1,
        ASEL_NB   = 3'd2,
        ASEL_CLR  = 3'd3,
        ASEL_SEED = 3'd4
    } t_asel;

    typedef struct packed {
        t_gop       gop;
        t_asel      asel;
        logic [1:0] wkind;
        logic       sp_push;
        logic       sp_pop;
        logic       cur_load;
        logic       nb_load;
        logic [1:0] nb_dir;
        logic       scan_clr;
        logic       scan_inc;
        logic       cnt_inc_chg;
        logic       cnt_clr;
        logic       rem_inc;
        logic       seed_from_scan;
        logic       seed_from_pos;
    } t_cmd;

    typedef struct packed {
        logic [1:0] rdata;
        logic       sp_empty;
        logic       nb_ok;
        logic       scan_last;
        logic       clr_last;
        logic       pos_inside;
    } t_sts;

endpackage

`default_nettype wire

>>> hdl/grid_flood_fill_relabel.sv
// ----------------------------------------------------------------------------
// grid_flood_fill_relabel
// Grid of 2-bit cell kinds with write, read and 4-connected flood fill.
// ----------------------------------------------------------------------------
// Channel | Direction | Handshake           | Payload
// in      | to block  | i_in_valid/o_in_stall  | gffr_pkg::t_in
// out     | from block| o_out_valid/i_out_stall| gffr_pkg::t_out
// cfg     | to block  | i_cfg_valid/o_cfg_ready| index, data
//
// After reset a sweep clears all 8192 cells, one per cycle; no item is
// accepted until it ends. A fill reads the seed and each visited neighbour
// through the single grid memory port, plus a read per cell for the seed
// scan and the closing count scan. The result register holds while
// i_out_stall is high; the next item may be accepted meanwhile, but its
// result waits in the controller until the held one has been taken.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module grid_flood_fill_relabel (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_in_valid,
    output logic                 o_in_stall,
    input  wire gffr_pkg::t_in   i_in_data,
    output logic                 o_out_valid,
    input  wire logic            i_out_stall,
    output gffr_pkg::t_out       o_out_data,
    input  wire logic            i_cfg_valid,
    output logic                 o_cfg_ready,
    input  wire logic            i_cfg_index,
    input  wire logic [7:0]      i_cfg_data
);

    gffr_pkg::t_in  r_req;
    gffr_pkg::t_cmd cmd;
    gffr_pkg::t_sts sts;
    gffr_pkg::t_in  req_mux;
    logic [7:0]     r_width;
    logic [6:0]     r_height;
    logic [7:0]     w_eff;
    logic [6:0]     h_eff;
    logic           busy, done, fill_res, in_go, r_out_valid;
    logic [1:0]     status;
    logic [gffr_pkg::XW-1:0] seed_x;
    logic [gffr_pkg::YW-1:0] seed_y;
    logic [gffr_pkg::CW-1:0] chg, rem;
    gffr_pkg::t_out r_out;

    // Clamp the size registers to the legal range
    always_comb begin
        w_eff = (r_width == '0) ? 8'd1 :
                (r_width > 8'(gffr_pkg::MAX_WIDTH)) ? 8'(gffr_pkg::MAX_WIDTH) : r_width;
        h_eff = (r_height == '0) ? 7'd1 :
                (r_height > 7'(gffr_pkg::MAX_HEIGHT)) ? 7'(gffr_pkg::MAX_HEIGHT) : r_height;
    end

    // Accept whenever the controller is idle; a held result does not block
    assign o_in_stall  = busy;
    assign in_go       = i_in_valid && !o_in_stall;
    assign o_cfg_ready = 1'b1;
    assign req_mux     = in_go ? i_in_data : r_req;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width  <= 8'd128;
            r_height <= 7'd64;
        end else if (i_cfg_valid && o_cfg_ready) begin
            if (i_cfg_index == gffr_pkg::CFG_WIDTH) begin
                r_width <= i_cfg_data;
            end else begin
                r_height <= i_cfg_data[6:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_go) begin
            r_req <= i_in_data;
        end
    end

    gffr_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_go    (in_go),
        .i_req      (req_mux),
        .i_sts      (sts),
        .i_out_free (!r_out_valid),
        .o_cmd      (cmd),
        .o_busy     (busy),
        .o_done     (done),
        .o_status   (status),
        .o_fill_res (fill_res)
    );

    gffr_datapath u_dp (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cmd    (cmd),
        .i_req    (req_mux),
        .i_w_eff  (w_eff),
        .i_h_eff  (h_eff),
        .o_sts    (sts),
        .o_seed_x (seed_x),
        .o_seed_y (seed_y),
        .o_chg    (chg),
        .o_rem    (rem)
    );

    // Capture the result; hold it until the transfer completes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (done && !r_out_valid) begin
            r_out_valid <= 1'b1;
        end else if (r_out_valid && !i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (done && !r_out_valid) begin
            r_out.status          <= status;
            r_out.read_kind       <= (!fill_res && r_req.req_type == gffr_pkg::REQ_READ
                                      && status == gffr_pkg::ST_OK) ? sts.rdata : 2'd0;
            r_out.changed_count   <= (fill_res && status == gffr_pkg::ST_OK) ? chg : '0;
            r_out.remaining_count <= (fill_res && (status == gffr_pkg::ST_OK
                                      || status == gffr_pkg::ST_SAME)) ? rem : '0;
            r_out.seed_x <= (fill_res && (status == gffr_pkg::ST_OK
                             || (status == gffr_pkg::ST_SAME
                                 && r_req.req_type == gffr_pkg::REQ_FILL))) ? seed_x : '0;
            r_out.seed_y <= (fill_res && (status == gffr_pkg::ST_OK
                             || (status == gffr_pkg::ST_SAME
                                 && r_req.req_type == gffr_pkg::REQ_FILL))) ? seed_y : '0;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

endmodule

`default_nettype wire

>>> hdl/gffr_datapath.sv
// ----------------------------------------------------------------------------
// gffr_datapath
// Grid memory, fill stack, scan counter, coordinates and counters.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module gffr_datapath (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire gffr_pkg::t_cmd   i_cmd,
    input  wire gffr_pkg::t_in    i_req,
    input  wire logic [7:0]       i_w_eff,
    input  wire logic [6:0]       i_h_eff,
    output gffr_pkg::t_sts        o_sts,
    output logic [gffr_pkg::XW-1:0] o_seed_x,
    output logic [gffr_pkg::YW-1:0] o_seed_y,
    output logic [gffr_pkg::CW-1:0] o_chg,
    output logic [gffr_pkg::CW-1:0] o_rem
);

    logic [1:0]                r_grid [gffr_pkg::CELLS];
    logic [gffr_pkg::AW-1:0]   r_stack [gffr_pkg::CELLS];
    logic [1:0]                r_rdata;
    logic [gffr_pkg::AW-1:0]   r_top;
    logic [gffr_pkg::CW-1:0]   r_sp;
    logic [gffr_pkg::XW-1:0]   r_cx, r_nx, r_sx, r_seed_x;
    logic [gffr_pkg::YW-1:0]   r_cy, r_ny, r_sy, r_seed_y;
    logic                      r_nb_ok;
    logic [gffr_pkg::AW-1:0]   r_clr;
    logic [gffr_pkg::CW-1:0]   r_chg, r_rem;
    logic [gffr_pkg::AW-1:0]   addr;
    logic [gffr_pkg::XW:0]     nx_w;
    logic [gffr_pkg::YW:0]     ny_w;
    logic                      nb_ok;

    // Neighbour coordinate with one guard bit for underflow and overflow
    always_comb begin
        nx_w = {1'b0, r_cx};
        ny_w = {1'b0, r_cy};
        case (i_cmd.nb_dir)
            2'd0:    nx_w = {1'b0, r_cx} - 1'b1;
            2'd1:    nx_w = {1'b0, r_cx} + 1'b1;
            2'd2:    ny_w = {1'b0, r_cy} - 1'b1;
            default: ny_w = {1'b0, r_cy} + 1'b1;
        endcase
        nb_ok = ({1'b0, nx_w} < {1'b0, i_w_eff}) && ({1'b0, ny_w} < {1'b0, i_h_eff})
                && !nx_w[gffr_pkg::XW] && !ny_w[gffr_pkg::YW];
    end

    always_comb begin
        case (i_cmd.asel)
            gffr_pkg::ASEL_POS:  addr = {i_req.pos_y, i_req.pos_x};
            gffr_pkg::ASEL_SCAN: addr = {r_sy, r_sx};
            gffr_pkg::ASEL_NB:   addr = {r_ny, r_nx};
            gffr_pkg::ASEL_CLR:  addr = r_clr;
            gffr_pkg::ASEL_SEED: addr = {r_seed_y, r_seed_x};
            default:             addr = {r_ny, r_nx};
        endcase
    end

    // Grid memory: one port, registered read
    always_ff @(posedge i_clk) begin
        if (i_cmd.gop == gffr_pkg::GOP_WRITE) begin
            r_grid[addr] <= i_cmd.wkind;
        end
        if (i_cmd.gop == gffr_pkg::GOP_READ) begin
            r_rdata <= r_grid[addr];
        end
    end

    // Fill stack memory
    always_ff @(posedge i_clk) begin
        if (i_cmd.sp_push) begin
            r_stack[r_sp[gffr_pkg::AW-1:0]] <= addr;
        end
        if (i_cmd.sp_pop) begin
            r_top <= r_stack[r_sp[gffr_pkg::AW-1:0] - 1'b1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sp  <= '0;
            r_clr <= '0;
            r_chg <= '0;
            r_rem <= '0;
            r_sx  <= '0;
            r_sy  <= '0;
        end else begin
            r_clr <= r_clr + 1'b1;
            if (i_cmd.sp_push) begin
                r_sp <= r_sp + 1'b1;
            end else if (i_cmd.sp_pop) begin
                r_sp <= r_sp - 1'b1;
            end
            if (i_cmd.cnt_clr) begin
                r_chg <= '0;
                r_rem <= '0;
            end else begin
                if (i_cmd.cnt_inc_chg) begin
                    r_chg <= r_chg + 1'b1;
                end
                if (i_cmd.rem_inc && r_rdata == i_req.match_kind) begin
                    r_rem <= r_rem + 1'b1;
                end
            end
            if (i_cmd.scan_clr) begin
                r_sx <= '0;
                r_sy <= '0;
            end else if (i_cmd.scan_inc) begin
                if ({1'b0, r_sx} == i_w_eff - 1'b1) begin
                    r_sx <= '0;
                    r_sy <= r_sy + 1'b1;
                end else begin
                    r_sx <= r_sx + 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.cur_load) begin
            r_cx <= r_top[gffr_pkg::XW-1:0];
            r_cy <= r_top[gffr_pkg::AW-1:gffr_pkg::XW];
        end
        if (i_cmd.nb_load) begin
            r_nx    <= nx_w[gffr_pkg::XW-1:0];
            r_ny    <= ny_w[gffr_pkg::YW-1:0];
            r_nb_ok <= nb_ok;
        end
        if (i_cmd.seed_from_pos) begin
            r_seed_x <= i_req.pos_x;
            r_seed_y <= i_req.pos_y;
        end else if (i_cmd.seed_from_scan) begin
            r_seed_x <= r_sx;
            r_seed_y <= r_sy;
        end
    end

    assign o_sts.rdata      = r_rdata;
    assign o_sts.sp_empty   = (r_sp == '0);
    assign o_sts.nb_ok      = r_nb_ok;
    assign o_sts.scan_last  = ({1'b0, r_sx} == i_w_eff - 1'b1)
                              && ({1'b0, r_sy} == i_h_eff - 1'b1);
    assign o_sts.clr_last   = (r_clr == '1);
    assign o_sts.pos_inside = ({1'b0, i_req.pos_x} < i_w_eff)
                              && ({1'b0, i_req.pos_y} < i_h_eff);
    assign o_seed_x = r_seed_x;
    assign o_seed_y = r_seed_y;
    assign o_chg    = r_chg;
    assign o_rem    = r_rem;

endmodule

`default_nettype wire

>>> hdl/gffr_ctrl.sv
// ----------------------------------------------------------------------------
// gffr_ctrl
// Sequencer for requests: clear sweep, access, seed scan, fill and count.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "assert_macros.svh"

module gffr_ctrl (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_in_go,
    input  wire gffr_pkg::t_in   i_req,
    input  wire gffr_pkg::t_sts  i_sts,
    input  wire logic            i_out_free,
    output gffr_pkg::t_cmd       o_cmd,
    output logic                 o_busy,
    output logic                 o_done,
    output logic [1:0]           o_status,
    output logic                 o_fill_res
);

    typedef enum logic [3:0] {
        S_CLEAR, S_IDLE, S_RD_WAIT, S_SCAN_RD, S_SCAN_CHK, S_SEED, S_SEED_CHK,
        S_POP, S_POP_WAIT, S_NB_CALC, S_NB_RD, S_NB_CHK, S_CNT_RD,
        S_CNT_CHK, S_DONE
    } t_state;

    t_state     r_state;
    logic [1:0] r_dir;
    logic [1:0] r_status;
    logic       r_fill_res;
    logic       r_last;

    always_comb begin
        o_cmd       = '0;
        o_cmd.gop   = gffr_pkg::GOP_NONE;
        o_cmd.asel  = gffr_pkg::ASEL_NB;
        o_cmd.wkind = i_req.new_kind;
        o_cmd.nb_dir = r_dir;
        case (r_state)
            S_CLEAR: begin
                o_cmd.gop   = gffr_pkg::GOP_WRITE;
                o_cmd.asel  = gffr_pkg::ASEL_CLR;
                o_cmd.wkind = 2'd0;
            end
            S_IDLE: begin
                o_cmd.asel    = gffr_pkg::ASEL_POS;
                o_cmd.cnt_clr = i_in_go;
                o_cmd.scan_clr = i_in_go;
                if (i_in_go && i_sts.pos_inside) begin
                    if (i_req.req_type == gffr_pkg::REQ_WRITE) begin
                        o_cmd.gop = gffr_pkg::GOP_WRITE;
                    end else if (i_req.req_type == gffr_pkg::REQ_READ) begin
                        o_cmd.gop = gffr_pkg::GOP_READ;
                    end
                end
                o_cmd.seed_from_pos = i_in_go && i_req.req_type == gffr_pkg::REQ_FILL;
            end
            S_SCAN_RD: begin
                o_cmd.gop  = gffr_pkg::GOP_READ;
                o_cmd.asel = gffr_pkg::ASEL_SCAN;
            end
            S_SCAN_CHK: begin
                if (i_sts.rdata == i_req.match_kind) begin
                    o_cmd.seed_from_scan = 1'b1;
                end else begin
                    o_cmd.scan_inc = 1'b1;
                end
            end
            S_SEED: begin
                // Read the seed cell; rewind the scan for the closing count
                o_cmd.gop      = gffr_pkg::GOP_READ;
                o_cmd.asel     = gffr_pkg::ASEL_SEED;
                o_cmd.scan_clr = 1'b1;
            end
            S_SEED_CHK: begin
                o_cmd.asel = gffr_pkg::ASEL_SEED;
                if (i_sts.rdata == i_req.match_kind) begin
                    o_cmd.gop         = gffr_pkg::GOP_WRITE;
                    o_cmd.sp_push     = 1'b1;
                    o_cmd.cnt_inc_chg = 1'b1;
                end
            end
            S_POP: begin
                o_cmd.sp_pop = 1'b1;
            end
            S_POP_WAIT: begin
                o_cmd.cur_load = 1'b1;
            end
            S_NB_CALC: begin
                o_cmd.nb_load = 1'b1;
            end
            S_NB_RD: begin
                o_cmd.gop = i_sts.nb_ok ? gffr_pkg::GOP_READ : gffr_pkg::GOP_NONE;
            end
            S_NB_CHK: begin
                if (i_sts.nb_ok && i_sts.rdata == i_req.match_kind) begin
                    o_cmd.gop         = gffr_pkg::GOP_WRITE;
                    o_cmd.sp_push     = 1'b1;
                    o_cmd.cnt_inc_chg = 1'b1;
                end
            end
            S_CNT_RD: begin
                o_cmd.gop  = gffr_pkg::GOP_READ;
                o_cmd.asel = gffr_pkg::ASEL_SCAN;
                o_cmd.scan_inc = 1'b1;
            end
            S_CNT_CHK: begin
                o_cmd.rem_inc = 1'b1;
            end
            default: begin
            end
        endcase
    end

    // A matching seed is recolored and pushed like a neighbour; a seed that
    // does not match goes straight to the closing count.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_CLEAR;
            r_dir      <= '0;
            r_status   <= '0;
            r_fill_res <= 1'b0;
            r_last     <= 1'b0;
        end else begin
            case (r_state)
                S_CLEAR: begin
                    if (i_sts.clr_last) begin
                        r_state <= S_IDLE;
                    end
                end
                S_IDLE: begin
                    if (i_in_go) begin
                        r_fill_res <= i_req.req_type[1];
                        r_status   <= gffr_pkg::ST_OK;
                        case (i_req.req_type)
                            gffr_pkg::REQ_WRITE, gffr_pkg::REQ_READ: begin
                                if (!i_sts.pos_inside) begin
                                    r_status <= gffr_pkg::ST_COORD;
                                end
                                r_state <= S_RD_WAIT;
                            end
                            gffr_pkg::REQ_FILL: begin
                                if (!i_sts.pos_inside) begin
                                    r_status <= gffr_pkg::ST_COORD;
                                    r_state  <= S_DONE;
                                end else if (i_req.match_kind == i_req.new_kind) begin
                                    r_status <= gffr_pkg::ST_SAME;
                                    r_state  <= S_CNT_RD;
                                end else begin
                                    r_state <= S_SEED;
                                end
                            end
                            default: begin
                                if (i_req.match_kind == i_req.new_kind) begin
                                    r_status <= gffr_pkg::ST_SAME;
                                    r_state  <= S_CNT_RD;
                                end else begin
                                    r_state <= S_SCAN_RD;
                                end
                            end
                        endcase
                    end
                end
                S_RD_WAIT: r_state <= S_DONE;
                S_SCAN_RD: begin
                    r_last  <= i_sts.scan_last;
                    r_state <= S_SCAN_CHK;
                end
                S_SCAN_CHK: begin
                    if (i_sts.rdata == i_req.match_kind) begin
                        r_state <= S_SEED;
                    end else if (r_last) begin
                        r_status <= gffr_pkg::ST_NOMATCH;
                        r_state  <= S_DONE;
                    end else begin
                        r_state <= S_SCAN_RD;
                    end
                end
                S_SEED: r_state <= S_SEED_CHK;
                S_SEED_CHK: begin
                    r_state <= o_cmd.sp_push ? S_POP : S_CNT_RD;
                end
                S_POP: r_state <= S_POP_WAIT;
                S_POP_WAIT: begin
                    r_dir   <= 2'd0;
                    r_state <= S_NB_CALC;
                end
                S_NB_CALC: r_state <= S_NB_RD;
                S_NB_RD: r_state <= S_NB_CHK;
                S_NB_CHK: begin
                    if (r_dir != 2'd3) begin
                        r_dir   <= r_dir + 1'b1;
                        r_state <= S_NB_CALC;
                    end else if (!i_sts.sp_empty || o_cmd.sp_push) begin
                        r_state <= S_POP;
                    end else begin
                        r_state <= S_CNT_RD;
                    end
                end
                S_CNT_RD: begin
                    r_last  <= i_sts.scan_last;
                    r_state <= S_CNT_CHK;
                end
                S_CNT_CHK: begin
                    r_state <= r_last ? S_DONE : S_CNT_RD;
                end
                S_DONE: begin
                    if (i_out_free) begin
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_busy     = (r_state != S_IDLE);
    assign o_done     = (r_state == S_DONE);
    assign o_status   = r_status;
    assign o_fill_res = r_fill_res;

    `ASSERT_IMPL(a_push_only_chk, i_clk, i_rst_n, o_cmd.sp_push, r_state == S_NB_CHK || r_state == S_SEED_CHK, "push outside cell check")
    `ASSERT_IMPL(a_pop_nonempty, i_clk, i_rst_n, o_cmd.sp_pop, !i_sts.sp_empty, "pop of empty stack")
    `ASSERT_NEXT(a_idle_stack_empty, i_clk, i_rst_n, r_state == S_CNT_RD && $past(r_state) == S_NB_CHK, i_sts.sp_empty, "stack not empty after fill")

endmodule

`default_nettype wire

>>> tb/tb_grid_flood_fill_relabel.sv
// ----------------------------------------------------------------------------
// tb_grid_flood_fill_relabel
// Self-checking bench: directed and random requests, shadow grid prediction.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module tb_grid_flood_fill_relabel;

    localparam logic [1:0] KIND_NONE  = 2'd0;
    localparam logic [1:0] KIND_EMPTY = 2'd1;
    localparam logic [1:0] KIND_WALL  = 2'd2;
    localparam logic [1:0] KIND_TMP   = 2'd3;

    logic                i_clk;
    logic                i_rst_n;
    logic                i_in_valid;
    logic                o_in_stall;
    gffr_pkg::t_in       i_in_data;
    logic                o_out_valid;
    logic                i_out_stall;
    gffr_pkg::t_out      o_out_data;
    logic                i_cfg_valid;
    logic                o_cfg_ready;
    logic                i_cfg_index;
    logic [7:0]          i_cfg_data;

    grid_flood_fill_relabel u_top (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_in_valid(i_in_valid), .o_in_stall(o_in_stall), .i_in_data(i_in_data),
        .o_out_valid(o_out_valid), .i_out_stall(i_out_stall), .o_out_data(o_out_data),
        .i_cfg_valid(i_cfg_valid), .o_cfg_ready(o_cfg_ready),
        .i_cfg_index(i_cfg_index), .i_cfg_data(i_cfg_data)
    );

    // Shadow state of the block
    logic [1:0]      shadow_grid [gffr_pkg::CELLS];
    int              fill_stack_a [gffr_pkg::CELLS];
    int              fill_depth;
    logic [7:0]      width_reg;
    logic [6:0]      height_reg;
    gffr_pkg::t_out  pending_results [$];
    int              error_count;
    longint          cycle_count;

    localparam longint CYCLE_LIMIT = 64'd40_000_000;

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    // Bound the run; a hang ends in failure
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    function automatic int eff_w();
        if (width_reg == 0) return 1;
        if (width_reg > gffr_pkg::MAX_WIDTH) return gffr_pkg::MAX_WIDTH;
        return int'(width_reg);
    endfunction

    function automatic int eff_h();
        if (height_reg == 0) return 1;
        if (height_reg > gffr_pkg::MAX_HEIGHT) return gffr_pkg::MAX_HEIGHT;
        return int'(height_reg);
    endfunction

    function automatic int count_of_kind(logic [1:0] k);
        int n;
        n = 0;
        for (int y = 0; y < eff_h(); y++)
            for (int x = 0; x < eff_w(); x++)
                if (shadow_grid[y * gffr_pkg::MAX_WIDTH + x] == k) n++;
        return n;
    endfunction

    // Recolor one cell and push it when it matches
    function automatic void relabel_cell(int x, int y, logic [1:0] m, logic [1:0] nk,
                                         ref int changed);
        int a;
        if (x < 0 || y < 0 || x >= eff_w() || y >= eff_h()) return;
        a = y * gffr_pkg::MAX_WIDTH + x;
        if (shadow_grid[a] != m) return;
        shadow_grid[a] = nk;
        changed++;
        if (fill_depth < gffr_pkg::CELLS) begin
            fill_stack_a[fill_depth] = a;
            fill_depth++;
        end
    endfunction

    function automatic int flood_region(int sx, int sy, logic [1:0] m, logic [1:0] nk);
        int changed;
        int a;
        int cx;
        int cy;
        changed = 0;
        fill_depth = 0;
        relabel_cell(sx, sy, m, nk, changed);
        while (fill_depth > 0) begin
            fill_depth--;
            a = fill_stack_a[fill_depth];
            cx = a % gffr_pkg::MAX_WIDTH;
            cy = a / gffr_pkg::MAX_WIDTH;
            relabel_cell(cx - 1, cy, m, nk, changed);
            relabel_cell(cx + 1, cy, m, nk, changed);
            relabel_cell(cx, cy - 1, m, nk, changed);
            relabel_cell(cx, cy + 1, m, nk, changed);
        end
        return changed;
    endfunction

    function automatic gffr_pkg::t_out predict_request(gffr_pkg::t_in r);
        gffr_pkg::t_out o;
        bit   in_grid;
        bit   found;
        int   a;
        o = '0;
        o.status = gffr_pkg::ST_OK;
        in_grid = (r.pos_x < eff_w()) && (r.pos_y < eff_h());
        a = r.pos_y * gffr_pkg::MAX_WIDTH + r.pos_x;
        case (gffr_pkg::t_req'(r.req_type))
            gffr_pkg::REQ_WRITE: begin
                if (in_grid) shadow_grid[a] = r.new_kind;
                else o.status = gffr_pkg::ST_COORD;
            end
            gffr_pkg::REQ_READ: begin
                if (in_grid) o.read_kind = shadow_grid[a];
                else o.status = gffr_pkg::ST_COORD;
            end
            gffr_pkg::REQ_FILL: begin
                if (!in_grid) begin
                    o.status = gffr_pkg::ST_COORD;
                end else begin
                    o.seed_x = r.pos_x;
                    o.seed_y = r.pos_y;
                    if (r.match_kind == r.new_kind) o.status = gffr_pkg::ST_SAME;
                    else o.changed_count = 14'(flood_region(r.pos_x, r.pos_y,
                                                            r.match_kind, r.new_kind));
                    o.remaining_count = 14'(count_of_kind(r.match_kind));
                end
            end
            default: begin
                if (r.match_kind == r.new_kind) begin
                    o.status = gffr_pkg::ST_SAME;
                    o.remaining_count = 14'(count_of_kind(r.match_kind));
                end else begin
                    found = 0;
                    for (int y = 0; y < eff_h() && !found; y++)
                        for (int x = 0; x < eff_w() && !found; x++)
                            if (shadow_grid[y * gffr_pkg::MAX_WIDTH + x] == r.match_kind) begin
                                found = 1;
                                o.seed_x = 7'(x);
                                o.seed_y = 6'(y);
                            end
                    if (!found) begin
                        o.status = gffr_pkg::ST_NOMATCH;
                    end else begin
                        o.changed_count = 14'(flood_region(o.seed_x, o.seed_y,
                                                           r.match_kind, r.new_kind));
                        o.remaining_count = 14'(count_of_kind(r.match_kind));
                    end
                end
            end
        endcase
        return o;
    endfunction

    task automatic report_mismatch(string what, int got, int want);
        $display("mismatch %s: got %0d want %0d at cycle %0d", what, got, want,
                 cycle_count);
        error_count++;
    endtask

    // Receive side: random stall per result, checked field by field
    initial begin
        int gap;
        forever begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 12);
            if (gap != 0) begin
                i_out_stall <= 1'b1;
                repeat (gap) @(posedge i_clk);
            end
            i_out_stall <= 1'b0;
            @(posedge i_clk);
            while (o_out_valid !== 1'b1) @(posedge i_clk);
            // transfer happened at this edge
            if (pending_results.size() == 0) begin
                report_mismatch("unexpected result", 1, 0);
            end else begin
                gffr_pkg::t_out w;
                w = pending_results.pop_front();
                if (o_out_data.read_kind != w.read_kind)
                    report_mismatch("read_kind", int'(o_out_data.read_kind),
                                    int'(w.read_kind));
                if (o_out_data.changed_count != w.changed_count)
                    report_mismatch("changed_count", int'(o_out_data.changed_count),
                                    int'(w.changed_count));
                if (o_out_data.remaining_count != w.remaining_count)
                    report_mismatch("remaining_count", int'(o_out_data.remaining_count),
                                    int'(w.remaining_count));
                if (o_out_data.seed_x != w.seed_x)
                    report_mismatch("seed_x", int'(o_out_data.seed_x), int'(w.seed_x));
                if (o_out_data.seed_y != w.seed_y)
                    report_mismatch("seed_y", int'(o_out_data.seed_y), int'(w.seed_y));
                if (o_out_data.status != w.status)
                    report_mismatch("status", int'(o_out_data.status), int'(w.status));
            end
        end
    end

    // Send one request after a random gap; predict on transfer. Valid stays
    // high after the transfer until the next gap or drain drops it.
    task automatic send_request(gffr_pkg::t_req rt, int x, int y, int m, int nk);
        gffr_pkg::t_in r;
        int  gap;
        gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 12);
        r.req_type = rt;
        r.pos_x = 7'(x);
        r.pos_y = 6'(y);
        r.match_kind = 2'(m);
        r.new_kind = 2'(nk);
        if (gap != 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_data <= r;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        pending_results = {pending_results, predict_request(r)};
    endtask

    task automatic wait_drained();
        i_in_valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);
    endtask

    // Hold until idle, then transfer one register write
    task automatic write_register(logic idx, logic [7:0] val);
        wait_drained();
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= val;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        i_cfg_valid <= 1'b0;
        if (idx == gffr_pkg::CFG_WIDTH) width_reg = val;
        else height_reg = val[6:0];
    endtask

    task automatic send_random_request(int bias_small);
        int x, y;
        if (bias_small) begin
            x = $urandom_range(0, eff_w());
            y = $urandom_range(0, eff_h());
        end else begin
            x = $urandom_range(0, 127);
            y = $urandom_range(0, 63);
        end
        send_request(gffr_pkg::t_req'($urandom_range(0, 3)), x, y,
                     $urandom_range(0, 3), $urandom_range(0, 3));
    endtask

    // Full-size grid: extremes of coordinates, every request, same-kind fill
    task automatic test_directed_full();
        send_request(gffr_pkg::REQ_READ, 127, 63, KIND_NONE, KIND_NONE);
        send_request(gffr_pkg::REQ_WRITE, 127, 63, KIND_NONE, KIND_WALL);
        send_request(gffr_pkg::REQ_READ, 127, 63, KIND_NONE, KIND_NONE);
        send_request(gffr_pkg::REQ_WRITE, 0, 0, KIND_NONE, KIND_TMP);
        send_request(gffr_pkg::REQ_FILL, 5, 5, KIND_NONE, KIND_NONE);   // match equals new
        send_request(gffr_pkg::REQ_FIRST, 0, 0, KIND_EMPTY, KIND_EMPTY); // match equals new
        send_request(gffr_pkg::REQ_FIRST, 0, 0, KIND_EMPTY, KIND_WALL); // nothing holds kind 1
        send_request(gffr_pkg::REQ_FILL, 0, 0, KIND_NONE, KIND_EMPTY);  // seed not of match kind
        send_request(gffr_pkg::REQ_FILL, 1, 0, KIND_NONE, KIND_EMPTY);  // whole grid but two cells
        send_request(gffr_pkg::REQ_FIRST, 0, 0, KIND_EMPTY, KIND_NONE);
        send_request(gffr_pkg::REQ_READ, 64, 32, KIND_NONE, KIND_NONE);
    endtask

    // Small grid: outside coordinates, wall splits region, edges
    task automatic test_directed_small();
        write_register(gffr_pkg::CFG_WIDTH, 8'd4);
        write_register(gffr_pkg::CFG_HEIGHT, 8'd3);
        for (int y = 0; y < 3; y++)
            send_request(gffr_pkg::REQ_WRITE, 2, y, KIND_NONE, KIND_WALL);
        send_request(gffr_pkg::REQ_WRITE, 4, 0, KIND_NONE, KIND_EMPTY);  // column outside
        send_request(gffr_pkg::REQ_READ, 0, 3, KIND_NONE, KIND_NONE);    // row outside
        send_request(gffr_pkg::REQ_FILL, 3, 2, KIND_NONE, KIND_EMPTY);
        send_request(gffr_pkg::REQ_FILL, 9, 1, KIND_EMPTY, KIND_NONE);   // seed outside
        send_request(gffr_pkg::REQ_FIRST, 0, 0, KIND_WALL, KIND_TMP);
    endtask

    task automatic test_register_extremes();
        write_register(gffr_pkg::CFG_WIDTH, 8'd0);
        write_register(gffr_pkg::CFG_HEIGHT, 8'd0);
        send_request(gffr_pkg::REQ_WRITE, 0, 0, KIND_NONE, KIND_WALL);
        send_request(gffr_pkg::REQ_FILL, 0, 0, KIND_WALL, KIND_EMPTY);
        send_request(gffr_pkg::REQ_READ, 1, 0, KIND_NONE, KIND_NONE);
        write_register(gffr_pkg::CFG_WIDTH, 8'd255);
        write_register(gffr_pkg::CFG_HEIGHT, 8'd127);
        send_request(gffr_pkg::REQ_READ, 127, 63, KIND_NONE, KIND_NONE);
        send_request(gffr_pkg::REQ_FIRST, 0, 0, KIND_WALL, KIND_NONE);
    endtask

    // Mostly small grids with random writes and requests; a few full-size
    task automatic test_random_requests();
        for (int phase = 0; phase < 6; phase++) begin
            if (phase == 5) begin
                write_register(gffr_pkg::CFG_WIDTH, 8'd128);
                write_register(gffr_pkg::CFG_HEIGHT, 8'd64);
                repeat (6) send_random_request(0);
            end else begin
                write_register(gffr_pkg::CFG_WIDTH, 8'($urandom_range(1, 12)));
                write_register(gffr_pkg::CFG_HEIGHT, 8'($urandom_range(1, 10)));
                repeat (18) begin
                    if ($urandom_range(0, 1))
                        send_request(gffr_pkg::REQ_WRITE, $urandom_range(0, eff_w() - 1),
                                     $urandom_range(0, eff_h() - 1), 0,
                                     $urandom_range(0, 3));
                    else
                        send_random_request(1);
                end
            end
        end
    endtask

    initial begin
        error_count = 0;
        cycle_count = 0;
        fill_depth = 0;
        width_reg = 8'd128;
        height_reg = 7'd64;
        for (int i = 0; i < gffr_pkg::CELLS; i++) shadow_grid[i] = KIND_NONE;
        i_rst_n = 1'b0;
        i_in_valid = 1'b0;
        i_in_data = '0;
        i_out_stall = 1'b0;
        i_cfg_valid = 1'b0;
        i_cfg_index = gffr_pkg::CFG_WIDTH;
        i_cfg_data = '0;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        test_directed_full();
        test_directed_small();
        test_register_extremes();
        test_random_requests();
        wait_drained();
        if (error_count == 0) $display("[ OK ] regression clean");
        else $display("[FAIL] regression broken");
        $finish;
    end
endmodule

`default_nettype wire
